### sv/fixed_frame_byte_parser_defines.svh
// Assertion macros for the fixed-frame byte parser.
`ifndef FIXED_FRAME_BYTE_PARSER_DEFINES_SVH
`define FIXED_FRAME_BYTE_PARSER_DEFINES_SVH

`ifndef ASSERT_OFF
// Same-cycle implication, checked on clk, disabled in reset.
`define FFBP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication, checked on clk, disabled in reset.
`define FFBP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define FFBP_ASSERT_NOW(label, ante, cons, msg)
`define FFBP_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

### sv/ffbp_pkg.sv
// Shared types and constants for the fixed-frame byte parser.
`timescale 1ns / 1ps
package ffbp_pkg;

  localparam int PortW    = 4;
  localparam int ByteW    = 8;
  localparam int DataN    = 10;
  localparam int CountW   = 4;
  localparam int StateW   = 3;
  localparam int InTdataW = 16;
  localparam int OutTdataW = (DataN + 1) * ByteW;

  localparam logic [ByteW-1:0] HDR_FIRST  = 8'h55;
  localparam logic [ByteW-1:0] HDR_SECOND = 8'hAA;
  localparam logic [ByteW-1:0] TAIL_MARK  = 8'hFF;

  localparam logic [CountW-1:0] DATA_LAST = CountW'(DataN);

  localparam logic [StateW-1:0] ST_HUNT = 3'd0;
  localparam logic [StateW-1:0] ST_HDR2 = 3'd1;
  localparam logic [StateW-1:0] ST_CTRL = 3'd2;
  localparam logic [StateW-1:0] ST_DATA = 3'd3;
  localparam logic [StateW-1:0] ST_CRC  = 3'd4;
  localparam logic [StateW-1:0] ST_CNT  = 3'd5;
  localparam logic [StateW-1:0] ST_TAIL = 3'd6;

  typedef logic [ByteW-1:0] byte_t;

  typedef struct packed {
    logic [PortW-1:0] port;
    byte_t            rx_byte;
  } beat_t;

  // ctrl in the low byte, data_0 above it, data_9 on top
  typedef struct packed {
    byte_t [DataN-1:0] data;
    byte_t             ctrl;
  } frame_t;

  typedef struct packed {
    logic              emit;
    logic [StateW-1:0] state;
    logic [CountW-1:0] count;
  } parse_stat_t;

endpackage

### sv/fixed_frame_byte_parser.sv
// Top level of the fixed-frame byte parser.
//
//  channel   dir  fields (low bit up)
//  s_axis    in   tdata: source_port[3:0], rx_byte[11:4], zero pad [15:12]
//  m_axis    out  tdata: frame_ctrl[7:0], data_0[15:8] .. data_9[87:80]
//  cfg       in   cfg_we, cfg_wdata: listen_port[3:0]
//
// One byte beat per cycle unless a waiting frame stalls: a beat is registered, then
// parsed as it advances; a frame it completes is loaded into the output register then.
// The input register advances whenever the output register is empty or draining,
// so one more beat is taken while a frame waits.
// rst is synchronous; it clears the state to the header hunt and empties both
// registers. Bytes from ports other than listen_port are consumed and dropped.
`timescale 1ns / 1ps
`include "fixed_frame_byte_parser_defines.svh"
module fixed_frame_byte_parser (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [ffbp_pkg::InTdataW-1:0] s_tdata,   // source_port, rx_byte, pad
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [ffbp_pkg::OutTdataW-1:0] m_tdata,  // frame_ctrl, data_0 .. data_9
  input  logic                          cfg_we,
  input  logic [ffbp_pkg::PortW-1:0]    cfg_wdata
);

  ffbp_pkg::beat_t       in_beat, held_beat;
  logic                  held_valid;
  logic                  out_free;
  logic                  advance;
  ffbp_pkg::parse_stat_t stat;
  ffbp_pkg::frame_t      frame, out_frame;

  assign in_beat.port    = s_tdata[ffbp_pkg::PortW-1:0];
  assign in_beat.rx_byte = s_tdata[ffbp_pkg::PortW +: ffbp_pkg::ByteW];
  assign advance         = held_valid && out_free;

  ffbp_in_reg u_in (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .in_beat    (in_beat),
    .held_valid (held_valid),
    .held_beat  (held_beat),
    .advance    (advance)
  );

  ffbp_parser u_parse (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .step      (advance),
    .beat      (held_beat),
    .stat      (stat),
    .frame     (frame)
  );

  // capture the finished frame when a matching tail byte completes it
  ffbp_out_reg u_out (
    .clk        (clk),
    .rst        (rst),
    .load       (stat.emit),
    .load_frame (frame),
    .free       (out_free),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_frame  (out_frame)
  );

  assign m_tdata = out_frame;

  `FFBP_ASSERT_NOW(a_emit_on_tail, stat.emit, stat.state == ffbp_pkg::ST_TAIL, "frame emitted outside tail state")
  `FFBP_ASSERT_NOW(a_stall_cause, s_tvalid && !s_tready, m_tvalid && !m_tready, "input stalled without a waiting frame")
  `FFBP_ASSERT_NOW(a_count_range, stat.state == ffbp_pkg::ST_DATA, stat.count < ffbp_pkg::DATA_LAST, "data count out of range")
  `FFBP_ASSERT_NEXT(a_emit_to_out, stat.emit, m_tvalid && stat.state == ffbp_pkg::ST_HUNT, "emitted frame not presented")

endmodule

### sv/ffbp_in_reg.sv
// Input register stage for received byte beats.
`timescale 1ns / 1ps
module ffbp_in_reg (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  ffbp_pkg::beat_t in_beat,
  output logic           held_valid,
  output ffbp_pkg::beat_t held_beat,
  input  logic           advance
);

  logic valid;
  ffbp_pkg::beat_t beat;

  assign in_ready   = !valid || advance;
  assign held_valid = valid;
  assign held_beat  = beat;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      beat <= in_beat;
    end
  end

endmodule

### sv/ffbp_parser.sv
// Frame parser state machine with capture registers and port filter.
`timescale 1ns / 1ps
module ffbp_parser (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [ffbp_pkg::PortW-1:0] cfg_wdata,
  input  logic                       step,
  input  ffbp_pkg::beat_t            beat,
  output ffbp_pkg::parse_stat_t      stat,
  output ffbp_pkg::frame_t           frame
);

  logic [ffbp_pkg::PortW-1:0]  listen_port;
  logic [ffbp_pkg::StateW-1:0] state, state_next;
  logic [ffbp_pkg::CountW-1:0] count, count_next;
  ffbp_pkg::byte_t             ctrl_hold;
  ffbp_pkg::byte_t [ffbp_pkg::DataN-1:0] data_hold;
  logic                        ours;
  logic                        emit;

  assign ours = step && (beat.port == listen_port);

  always_comb begin
    state_next = state;
    count_next = count;
    emit       = 1'b0;
    case (state)
      ffbp_pkg::ST_HUNT: begin
        if (beat.rx_byte == ffbp_pkg::HDR_FIRST) state_next = ffbp_pkg::ST_HDR2;
      end
      ffbp_pkg::ST_HDR2: begin
        // a wrong second byte is not retried as a first header byte
        state_next = (beat.rx_byte == ffbp_pkg::HDR_SECOND) ?
                     ffbp_pkg::ST_CTRL : ffbp_pkg::ST_HUNT;
      end
      ffbp_pkg::ST_CTRL: begin
        count_next = '0;
        state_next = ffbp_pkg::ST_DATA;
      end
      ffbp_pkg::ST_DATA: begin
        count_next = count + 1'b1;
        if (count_next >= ffbp_pkg::DATA_LAST) state_next = ffbp_pkg::ST_CRC;
      end
      ffbp_pkg::ST_CRC: state_next = ffbp_pkg::ST_CNT;
      ffbp_pkg::ST_CNT: state_next = ffbp_pkg::ST_TAIL;
      ffbp_pkg::ST_TAIL: begin
        emit       = (beat.rx_byte == ffbp_pkg::TAIL_MARK);
        state_next = ffbp_pkg::ST_HUNT;
      end
      default: state_next = ffbp_pkg::ST_HUNT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      listen_port <= '0;
      state       <= ffbp_pkg::ST_HUNT;
      count       <= '0;
    end else begin
      if (cfg_we) listen_port <= cfg_wdata;
      if (ours) begin
        state <= state_next;
        count <= count_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ours && state == ffbp_pkg::ST_CTRL) ctrl_hold <= beat.rx_byte;
    if (ours && state == ffbp_pkg::ST_DATA && count < ffbp_pkg::DATA_LAST) begin
      data_hold[count] <= beat.rx_byte;
    end
  end

  assign stat.emit  = ours && emit;
  assign stat.state = state;
  assign stat.count = count;
  assign frame.ctrl = ctrl_hold;
  assign frame.data = data_hold;

endmodule

### sv/ffbp_out_reg.sv
// Output register holding one completed frame until the sink takes it.
`timescale 1ns / 1ps
module ffbp_out_reg (
  input  logic             clk,
  input  logic             rst,
  input  logic             load,
  input  ffbp_pkg::frame_t load_frame,
  output logic             free,
  output logic             out_valid,
  input  logic             out_ready,
  output ffbp_pkg::frame_t out_frame
);

  logic valid;
  ffbp_pkg::frame_t frame;

  assign free      = !valid || out_ready;
  assign out_valid = valid;
  assign out_frame = frame;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (out_ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) frame <= load_frame;
  end

endmodule
